// File: design/mdm_pkg.sv
// Shared types, constants and helpers of the mecanum drive mixer.
package mdm_pkg;

    localparam int VW     = 20;   // working width of signed axis and mix values
    localparam int NW     = 47;   // divider numerator width
    localparam int DW     = 31;   // divider denominator width
    localparam int PW     = 64;   // multiplier product width
    localparam int CXW    = 27;   // CORDIC vector width
    localparam int STEP_W = 5;    // CORDIC step index width
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 15;
    localparam int OUT_W  = 13;

    localparam logic [CFG_IW-1:0] REG_XY_DB     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_XY_MIN    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TW_DB     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TW_MIN    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ROT_GAIN  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_RAMP_W    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_OUT_SCALE = 3'd6;

    localparam logic [29:0] CORDIC_K  = 30'd652032874;
    localparam logic [15:0] INV_SQRT2 = 16'd23170;
    localparam logic [16:0] ONE_Q15   = 17'd32768;
    localparam logic [12:0] WHEEL_MAX = 13'd4095;

    typedef enum logic [28:0] {
        ST_IDLE    = 29'd1,
        ST_DB_T    = 29'd1 << 1,
        ST_DB_SQ   = 29'd1 << 2,
        ST_DB_NUM  = 29'd1 << 3,
        ST_DB_DEN  = 29'd1 << 4,
        ST_DB_DIV  = 29'd1 << 5,
        ST_DB_WAIT = 29'd1 << 6,
        ST_CO_INIT = 29'd1 << 7,
        ST_CO_STEP = 29'd1 << 8,
        ST_CO_GAIN = 29'd1 << 9,
        ST_CO_R    = 29'd1 << 10,
        ST_S_DIV   = 29'd1 << 11,
        ST_S_WAIT  = 29'd1 << 12,
        ST_C_DIV   = 29'd1 << 13,
        ST_C_WAIT  = 29'd1 << 14,
        ST_DA_MUL  = 29'd1 << 15,
        ST_DB2_MUL = 29'd1 << 16,
        ST_ROT_MUL = 29'd1 << 17,
        ST_DEN     = 29'd1 << 18,
        ST_PA_MUL  = 29'd1 << 19,
        ST_PB_MUL  = 29'd1 << 20,
        ST_TERM    = 29'd1 << 21,
        ST_W_MUL   = 29'd1 << 22,
        ST_W_DIV   = 29'd1 << 23,
        ST_W_WAIT  = 29'd1 << 24,
        ST_R_MUL1  = 29'd1 << 25,
        ST_R_MUL2  = 29'd1 << 26,
        ST_R_OUT   = 29'd1 << 27,
        ST_DONE    = 29'd1 << 28
    } t_state;

    typedef struct packed {
        t_state              state;
        logic                load;
        logic                publish;
        logic [1:0]          axis;
        logic [1:0]          wheel;
        logic [STEP_W-1:0]   step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

    // Divide by 2^15, rounding halves away from zero.
    function automatic logic signed [PW-1:0] rnd_q15(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        q   = (mag + PW'(16384)) >> 15;
        return v[PW-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// File: design/mdm_if.sv
// Valid/ready channel interfaces for joystick samples and wheel commands.
interface mdm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] joystick_x;
    logic signed [15:0] joystick_y;
    logic signed [15:0] joystick_twist;

    modport source (output valid, joystick_x, joystick_y, joystick_twist, input ready);
    modport sink   (input valid, joystick_x, joystick_y, joystick_twist, output ready);
endinterface

interface mdm_out_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] front_left_speed;
    logic signed [12:0] front_right_speed;
    logic signed [12:0] back_left_speed;
    logic signed [12:0] back_right_speed;

    modport source (output valid, front_left_speed, front_right_speed,
                    back_left_speed, back_right_speed, input ready);
    modport sink   (input valid, front_left_speed, front_right_speed,
                    back_left_speed, back_right_speed, output ready);
endinterface

// File: design/mdm_div.sv
// Restoring divider, one quotient bit per cycle, rounds to nearest.
module mdm_div
    import mdm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            // bias by half the divisor so truncation rounds to nearest
            n_q    = i_num + NW'(i_den >> 1);
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            n_q   = {r_q[NW-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: design/mdm_ctrl.sv
// Sequencer that steps the datapath through one sample.
module mdm_ctrl
    import mdm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [1:0]        r_axis, n_axis;
    logic [1:0]        r_wheel, n_wheel;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_wheel = r_wheel;
        n_step  = r_step;
        case (r_state)
            ST_IDLE:    if (i_in_valid) begin
                n_state = ST_DB_T;
                n_axis  = 2'd0;
            end
            ST_DB_T:    n_state = ST_DB_SQ;
            ST_DB_SQ:   n_state = ST_DB_NUM;
            ST_DB_NUM:  n_state = ST_DB_DEN;
            ST_DB_DEN:  n_state = ST_DB_DIV;
            ST_DB_DIV:  n_state = ST_DB_WAIT;
            ST_DB_WAIT: if (i_status.div_done) begin
                if (r_axis == 2'd2) begin
                    n_state = ST_CO_INIT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_DB_T;
                end
            end
            ST_CO_INIT: begin
                n_step  = '0;
                n_state = ST_CO_STEP;
            end
            ST_CO_STEP: begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = ST_CO_GAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_CO_GAIN: n_state = ST_CO_R;
            ST_CO_R:    n_state = ST_S_DIV;
            ST_S_DIV:   n_state = ST_S_WAIT;
            ST_S_WAIT:  if (i_status.div_done) n_state = ST_C_DIV;
            ST_C_DIV:   n_state = ST_C_WAIT;
            ST_C_WAIT:  if (i_status.div_done) n_state = ST_DA_MUL;
            ST_DA_MUL:  n_state = ST_DB2_MUL;
            ST_DB2_MUL: n_state = ST_ROT_MUL;
            ST_ROT_MUL: n_state = ST_DEN;
            ST_DEN:     n_state = ST_PA_MUL;
            ST_PA_MUL:  n_state = ST_PB_MUL;
            ST_PB_MUL:  n_state = ST_TERM;
            ST_TERM: begin
                n_wheel = 2'd0;
                n_state = ST_W_MUL;
            end
            ST_W_MUL:   n_state = ST_W_DIV;
            ST_W_DIV:   n_state = ST_W_WAIT;
            ST_W_WAIT:  if (i_status.div_done) n_state = ST_R_MUL1;
            ST_R_MUL1:  n_state = ST_R_MUL2;
            ST_R_MUL2:  n_state = ST_R_OUT;
            ST_R_OUT: begin
                if (r_wheel == 2'd3) begin
                    n_state = ST_DONE;
                end else begin
                    n_wheel = r_wheel + 2'd1;
                    n_state = ST_W_MUL;
                end
            end
            ST_DONE:    if (i_status.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
            r_wheel <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_wheel <= n_wheel;
            r_step  <= n_step;
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cmd.state   = r_state;
    assign o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.publish = (r_state == ST_DONE) && i_status.out_free;
    assign o_cmd.axis    = r_axis;
    assign o_cmd.wheel   = r_wheel;
    assign o_cmd.step    = r_step;

endmodule

// File: design/mdm_dp.sv
// Datapath: config registers, shared multiplier, divider, CORDIC and ramp state.
module mdm_dp
    import mdm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic signed [15:0]      i_jx,
    input  logic signed [15:0]      i_jy,
    input  logic signed [15:0]      i_jz,
    input  logic                    i_cfg_we,
    input  logic [CFG_IW-1:0]       i_cfg_idx,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [OUT_W-1:0] o_fl,
    output logic signed [OUT_W-1:0] o_fr,
    output logic signed [OUT_W-1:0] o_bl,
    output logic signed [OUT_W-1:0] o_br
);

    // configuration
    logic [14:0] r_xy_db, r_xy_min, r_tw_db, r_tw_min, r_gain, r_ramp_w;
    logic [11:0] r_scale;

    // sample and intermediate values
    logic signed [15:0]    r_jx, r_jy, r_jz;
    logic [16:0]           r_t;
    logic                  r_dz, r_dneg;
    logic [NW-1:0]         r_num;
    logic signed [PW-1:0]  r_prod, r_acc;
    logic signed [VW-1:0]  r_x, r_y, r_z, r_s, r_c, r_r, r_pw;
    logic signed [VW-1:0]  r_da, r_db, r_rot, r_pa, r_pb;
    logic [VW-1:0]         r_den;
    logic                  r_rzero, r_wneg;
    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [OUT_W-1:0] r_raw;
    logic signed [OUT_W-1:0] r_prev [4];
    logic signed [OUT_W-1:0] r_wout [4];
    logic signed [OUT_W-1:0] r_out  [4];
    logic                  r_out_valid;

    // shared multiplier
    logic signed [31:0]   mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;

    mdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    function automatic logic signed [CXW-1:0] shr_sym(input logic signed [CXW-1:0] v,
                                                     input logic [STEP_W-1:0] s);
        logic [CXW-1:0] m;
        m = v[CXW-1] ? CXW'(-v) : CXW'(v);
        m = m >> s;
        return v[CXW-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [VW-1:0] vabs(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    // deadband operand selection
    logic signed [15:0] db_in;
    logic [14:0]        db_d, db_m;
    logic [16:0]        db_mag, db_e, db_om;
    logic [16:0]        db_y;
    logic signed [VW-1:0] db_val;

    always_comb begin
        case (i_cmd.axis)
            2'd0:    db_in = r_jx;
            2'd1:    db_in = r_jy;
            default: db_in = r_jz;
        endcase
        db_d   = (i_cmd.axis == 2'd2) ? r_tw_db  : r_xy_db;
        db_m   = (i_cmd.axis == 2'd2) ? r_tw_min : r_xy_min;
        db_mag = db_in[15] ? 17'(-{db_in[15], db_in}) : 17'({1'b0, db_in});
        db_e   = ONE_Q15 - {2'b0, db_d};
        db_om  = ONE_Q15 - {2'b0, db_m};
        db_y   = r_dz ? 17'd0 : 17'(div_quo[16:0] + {2'b0, db_m});
        // x and y are negated, twist keeps its sign
        if ((i_cmd.axis == 2'd2) ^ r_dneg)
            db_val = $signed(VW'(db_y));
        else
            db_val = -$signed(VW'(db_y));
    end

    // wheel term selection
    logic signed [VW-1:0] term;
    always_comb begin
        case (i_cmd.wheel)
            2'd0:    term = r_pb + r_rot;
            2'd1:    term = r_rot - r_pa;
            2'd2:    term = r_pa + r_rot;
            default: term = r_rot - r_pb;
        endcase
    end

    logic [VW-1:0]        abs_x, abs_y, abs_da, abs_db;
    logic [VW-1:0]        r_calc;
    logic                 vec_zero;
    logic signed [VW-1:0] quo_s;
    logic [PW-1:0]        prod_mag;
    logic [12:0]          sat_mag;
    logic signed [PW-1:0] ramp_sum;

    assign abs_x    = vabs(r_x);
    assign abs_y    = vabs(r_y);
    assign abs_da   = vabs(r_da);
    assign abs_db   = vabs(r_db);
    assign r_calc   = VW'((r_prod + (64'sd1 <<< 37)) >>> 38);
    assign vec_zero = ((r_x == '0) && (r_y == '0)) || (r_calc == '0);
    assign quo_s    = $signed(div_quo[VW-1:0]);
    assign prod_mag = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign sat_mag  = (div_quo > NW'(WHEEL_MAX)) ? WHEEL_MAX : div_quo[12:0];
    assign ramp_sum = r_acc + r_prod;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DW'(1);
        case (i_cmd.state)
            ST_DB_SQ: begin
                mul_a = 32'($signed({1'b0, r_t}));
                mul_b = 32'($signed({1'b0, r_t}));
            end
            ST_DB_NUM: begin
                mul_a = 32'($signed({1'b0, db_om}));
                mul_b = $signed({1'b0, r_prod[30:0]});
            end
            ST_DB_DEN: begin
                mul_a = 32'($signed({1'b0, db_e}));
                mul_b = 32'($signed({1'b0, db_e}));
            end
            ST_DB_DIV: begin
                div_start = 1'b1;
                div_num   = r_num;
                div_den   = r_prod[DW-1:0];
            end
            ST_CO_GAIN: begin
                mul_a = r_cx[CXW-1] ? 32'sd0 : 32'(r_cx);
                mul_b = 32'($signed({1'b0, CORDIC_K}));
            end
            ST_S_DIV, ST_C_DIV: begin
                div_start = 1'b1;
                div_num   = NW'((i_cmd.state == ST_S_DIV) ? abs_y : abs_x) << 15;
                div_den   = (r_r == '0) ? DW'(1) : DW'(r_r);
            end
            ST_DA_MUL: begin
                mul_a = 32'(r_s) + 32'(r_c);
                mul_b = 32'($signed({1'b0, INV_SQRT2}));
            end
            ST_DB2_MUL: begin
                mul_a = 32'(r_s) - 32'(r_c);
                mul_b = 32'($signed({1'b0, INV_SQRT2}));
            end
            ST_ROT_MUL: begin
                mul_a = 32'(r_z);
                mul_b = 32'($signed({1'b0, r_gain}));
            end
            ST_PA_MUL: begin
                mul_a = 32'(r_da);
                mul_b = 32'(r_pw);
            end
            ST_PB_MUL: begin
                mul_a = 32'(r_db);
                mul_b = 32'(r_pw);
            end
            ST_W_MUL: begin
                mul_a = 32'(term);
                mul_b = 32'($signed({1'b0, r_scale}));
            end
            ST_W_DIV: begin
                div_start = 1'b1;
                div_num   = prod_mag[NW-1:0];
                div_den   = (r_den == '0) ? DW'(1) : DW'(r_den);
            end
            ST_R_MUL1: begin
                mul_a = 32'(r_raw);
                mul_b = 32'($signed({1'b0, r_ramp_w}));
            end
            ST_R_MUL2: begin
                mul_a = 32'(r_prev[i_cmd.wheel]);
                mul_b = 32'($signed(ONE_Q15 - {2'b0, r_ramp_w}));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xy_db     <= 15'd6554;
            r_xy_min    <= 15'd1638;
            r_tw_db     <= 15'd8192;
            r_tw_min    <= 15'd9830;
            r_gain      <= 15'd13107;
            r_ramp_w    <= 15'd19661;
            r_scale     <= 12'd2500;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) r_prev[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_XY_DB:     r_xy_db  <= i_cfg_data;
                    REG_XY_MIN:    r_xy_min <= i_cfg_data;
                    REG_TW_DB:     r_tw_db  <= i_cfg_data;
                    REG_TW_MIN:    r_tw_min <= i_cfg_data;
                    REG_ROT_GAIN:  r_gain   <= i_cfg_data;
                    REG_RAMP_W:    r_ramp_w <= i_cfg_data;
                    REG_OUT_SCALE: r_scale  <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_cmd.publish)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            if (i_cmd.state == ST_R_OUT)
                r_prev[i_cmd.wheel] <= r_raw;
        end

        if (i_cmd.load) begin
            r_jx <= i_jx;
            r_jy <= i_jy;
            r_jz <= i_jz;
        end
        if (i_cmd.publish) begin
            for (int k = 0; k < 4; k++) r_out[k] <= r_wout[k];
        end

        case (i_cmd.state)
            ST_DB_T: begin
                r_dz   <= db_mag <= {2'b0, db_d};
                r_t    <= db_mag - {2'b0, db_d};
                r_dneg <= db_in[15];
            end
            ST_DB_SQ, ST_DB_NUM, ST_CO_GAIN, ST_DA_MUL, ST_DB2_MUL, ST_ROT_MUL,
            ST_PA_MUL, ST_PB_MUL, ST_W_MUL, ST_R_MUL1:
                r_prod <= mul_p;
            ST_DB_DEN: begin
                r_num  <= r_prod[NW-1:0];
                r_prod <= mul_p;
            end
            ST_DB_WAIT: if (div_done) begin
                case (i_cmd.axis)
                    2'd0:    r_x <= db_val;
                    2'd1:    r_y <= db_val;
                    default: r_z <= db_val;
                endcase
            end
            ST_CO_INIT: begin
                r_cx <= $signed(CXW'(abs_x) << 8);
                r_cy <= $signed(CXW'(abs_y) << 8);
            end
            ST_CO_STEP: begin
                if (!r_cy[CXW-1]) begin
                    r_cx <= r_cx + shr_sym(r_cy, i_cmd.step);
                    r_cy <= r_cy - shr_sym(r_cx, i_cmd.step);
                end else begin
                    r_cx <= r_cx - shr_sym(r_cy, i_cmd.step);
                    r_cy <= r_cy + shr_sym(r_cx, i_cmd.step);
                end
            end
            ST_CO_R: begin
                r_rzero <= vec_zero;
                r_r     <= vec_zero ? '0 : $signed(r_calc);
            end
            ST_S_WAIT: if (div_done) begin
                r_s <= r_rzero ? '0 : (r_y[VW-1] ? -quo_s : quo_s);
            end
            ST_C_WAIT: if (div_done) begin
                r_c <= r_rzero ? $signed(VW'(ONE_Q15)) : (r_x[VW-1] ? -quo_s : quo_s);
            end
            default: ;
        endcase

        // fixed-point mix and ramp steps; most round the previous product
        case (i_cmd.state)
            ST_DA_MUL:  r_pw  <= (r_r > $signed(VW'(ONE_Q15))) ? $signed(VW'(ONE_Q15)) : r_r;
            ST_DB2_MUL: r_da  <= VW'(rnd_q15(r_prod));
            ST_ROT_MUL: r_db  <= VW'(rnd_q15(r_prod));
            ST_DEN:     r_rot <= VW'(rnd_q15(r_prod));
            ST_PA_MUL:  r_den <= ((abs_da >= abs_db) ? abs_da : abs_db) + vabs(r_rot);
            ST_PB_MUL:  r_pa  <= VW'(rnd_q15(r_prod));
            ST_TERM:    r_pb  <= VW'(rnd_q15(r_prod));
            ST_W_DIV:   r_wneg <= r_prod[PW-1];
            ST_W_WAIT: if (div_done) begin
                if (r_den == '0)
                    r_raw <= '0;
                else
                    r_raw <= r_wneg ? -$signed(sat_mag) : $signed(sat_mag);
            end
            ST_R_MUL2: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            ST_R_OUT:   r_wout[i_cmd.wheel] <= OUT_W'(rnd_q15(ramp_sum));
            default: ;
        endcase
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_fl = r_out[0];
    assign o_fr = r_out[1];
    assign o_bl = r_out[2];
    assign o_br = r_out[3];

endmodule

// File: design/mecanum_drive_mixer_core.sv
// Top level of the mecanum drive mixer: sequencer plus datapath.
//
// Usage:
//  - i_in carries one joystick transaction (x, y, twist, Q1.15 signed).
//    o_out carries one transaction of four ramped wheel speed commands.
//  - Configuration registers are written via i_cfg_we/i_cfg_idx/i_cfg_data,
//    by the user only while idle (not enforced); unknown indexes are dropped.
//  - One sample is worked at a time: i_in.ready is high only while idle.
//    A sample's time from accept to result is set by nine passes through
//    the shared divider, which retires one quotient bit per cycle (three
//    deadbands, sine and cosine, four wheel normalizations); the rest is
//    steps on the one shared multiplier and the CORDIC iterations.
//  - Results wait in an output register; the next sample is accepted
//    while that register is still held by a stalled receiver. If a new
//    result is finished before the old one is taken, hold the sequencer
//    until the receiver drains the register.
//  - Synchronous active-low reset restores the register defaults, zeroes
//    the previous raw wheel values and drops any pending result.
module mecanum_drive_mixer_core
    import mdm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mdm_in_if.sink            i_in,
    mdm_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer: owns the step order, counters for axis, wheel and CORDIC step
    mdm_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: config, multiplier, divider, CORDIC vector and ramp history
    mdm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_jx        (i_in.joystick_x),
        .i_jy        (i_in.joystick_y),
        .i_jz        (i_in.joystick_twist),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_fl        (o_out.front_left_speed),
        .o_fr        (o_out.front_right_speed),
        .o_bl        (o_out.back_left_speed),
        .o_br        (o_out.back_right_speed)
    );

endmodule
